[design/convex_polygon_sat_collision_assert.svh]
// assertion macros for the polygon collision checker
`ifndef CONVEX_POLYGON_SAT_COLLISION_ASSERT_SVH
`define CONVEX_POLYGON_SAT_COLLISION_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CPSAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CPSAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cpsat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsat_pkg
// Shared types and constants of the polygon separating-axis collision block.
// ----------------------------------------------------------------------------
package cpsat_pkg;

  localparam int NUM_W     = 48;  // divider dividend width
  localparam int DEN_W     = 32;  // divider divisor width
  localparam int MIN_VERTS = 3;

  localparam logic POLY_A = 1'b0;
  localparam logic POLY_B = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_WRITE,
    OP_LATCH_I,
    OP_EDGE,
    OP_NORM,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_X,
    OP_SET_NX,
    OP_DIV_Y,
    OP_SET_NY,
    OP_TEST_INIT,
    OP_PROJ_INIT,
    OP_PROJ_MUL,
    OP_PROJ_ACC,
    OP_CMP,
    OP_SUM_INIT,
    OP_SUM_ACC,
    OP_DIV_CX,
    OP_SET_CX,
    OP_DIV_CY,
    OP_SET_CY,
    OP_DOT_MUL,
    OP_DOT_FIX
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel;
  } dp_cmd_t;

  typedef struct packed {
    logic edge_zero;
    logic norm_ok;
    logic sqrt_done;
    logic div_busy;
    logic gap;
    logic have;
  } dp_stat_t;

endpackage

[design/cpsat_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsat_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpsat_div
  import cpsat_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_q;
  logic [DEN_W-1:0] r_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [DEN_W:0]   rr;
  logic             ge;

  assign rr = {r_q, q_q[NUM_W-1]};
  assign ge = rr >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      r_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      q_q <= {q_q[NUM_W-2:0], ge};
      r_q <= ge ? DEN_W'(rr - {1'b0, den_q}) : rr[DEN_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = q_q;

endmodule

[design/cpsat_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsat_dp
// Datapath: vertex stores, edge normal, normalization, square root,
// projections, overlap tracking, centroids and normal orientation.
// ----------------------------------------------------------------------------
module cpsat_dp
  import cpsat_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int AW           = 4,
  parameter int CW           = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  input  logic [AW-1:0]       addr_i,
  input  logic [CW-1:0]       cnt_i,
  input  logic signed [31:0]  vx_i,
  input  logic signed [31:0]  vy_i,
  output dp_stat_t            stat_o,
  output logic signed [17:0]  nx_o,
  output logic signed [17:0]  ny_o,
  output logic [30:0]         depth_o
);

  localparam int SW = 32 + $clog2(MAX_VERTICES);

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  logic [63:0] mem_a [MAX_VERTICES];
  logic [63:0] mem_b [MAX_VERTICES];
  logic [63:0] rd_q;

  logic signed [31:0] rdx, rdy;
  logic signed [31:0] px_q, py_q;
  logic signed [32:0] ex_q, ey_q, ex_w, ey_w;
  logic [32:0]        ax_q, ay_q, maxm;
  logic [61:0]        sqx, sqy;
  logic [63:0]        sq_q, sv_q, sr_q, sbit_q, st;
  logic signed [17:0] nx_q, ny_q, bnx_q, bny_q, qn;
  logic signed [49:0] mx_q, my_q;
  logic signed [50:0] dproj;
  logic signed [50:0] lo_a_q, hi_a_q, lo_b_q, hi_b_q, mnh, mxl;
  logic               first_a_q, first_b_q, have_q, gap;
  logic signed [51:0] best_q, ov;
  logic signed [SW-1:0] sx_q, sy_q;
  logic [SW-1:0]      sxa, sya;
  logic signed [32:0] cax_q, cay_q, cbx_q, cby_q, qc;
  logic signed [33:0] dx, dy;
  logic signed [51:0] m1_q, m2_q;
  logic signed [52:0] dsum;
  logic [31:0]        len;

  logic               div_start, div_busy;
  logic [NUM_W-1:0]   div_num, div_quo;
  logic [DEN_W-1:0]   div_den;

  assign rdx  = rd_q[31:0];
  assign rdy  = rd_q[63:32];
  assign ex_w = 33'(rdx) - 33'(px_q);
  assign ey_w = 33'(rdy) - 33'(py_q);
  assign maxm = (ax_q > ay_q) ? ax_q : ay_q;
  assign sqx  = ax_q[30:0] * ax_q[30:0];
  assign sqy  = ay_q[30:0] * ay_q[30:0];
  assign st   = sr_q + sbit_q;
  assign len  = sr_q[31:0];
  assign qn   = {1'b0, div_quo[16:0]};
  assign qc   = {1'b0, div_quo[31:0]};
  assign sxa  = sx_q[SW-1] ? SW'(-sx_q) : SW'(sx_q);
  assign sya  = sy_q[SW-1] ? SW'(-sy_q) : SW'(sy_q);
  assign dproj = 51'(mx_q) + 51'(my_q);
  assign gap  = (hi_a_q < lo_b_q) || (hi_b_q < lo_a_q);
  assign mnh  = (hi_a_q < hi_b_q) ? hi_a_q : hi_b_q;
  assign mxl  = (lo_a_q > lo_b_q) ? lo_a_q : lo_b_q;
  assign ov   = 52'(mnh) - 52'(mxl);
  assign dx   = 34'(cbx_q) - 34'(cax_q);
  assign dy   = 34'(cby_q) - 34'(cay_q);
  assign dsum = 53'(m1_q) + 53'(m2_q);

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = len;
    case (cmd_i.op)
      OP_DIV_X: begin
        div_start = 1'b1;
        div_num   = {ax_q[31:0], 16'b0} + NUM_W'(len[31:1]);
      end
      OP_DIV_Y: begin
        div_start = 1'b1;
        div_num   = {ay_q[31:0], 16'b0} + NUM_W'(len[31:1]);
      end
      OP_DIV_CX: begin
        div_start = 1'b1;
        div_num   = NUM_W'(sxa);
        div_den   = DEN_W'(cnt_i);
      end
      OP_DIV_CY: begin
        div_start = 1'b1;
        div_num   = NUM_W'(sya);
        div_den   = DEN_W'(cnt_i);
      end
      default: ;
    endcase
  end

  cpsat_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE) begin
      if (cmd_i.sel == POLY_B) begin
        mem_b[addr_i] <= {vy_i, vx_i};
      end else begin
        mem_a[addr_i] <= {vy_i, vx_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= (cmd_i.sel == POLY_B) ? mem_b[addr_i] : mem_a[addr_i];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH_I: begin
        px_q <= rdx;
        py_q <= rdy;
      end
      OP_EDGE: begin
        ex_q <= ex_w;
        ey_q <= ey_w;
        ax_q <= mag33(ey_w);
        ay_q <= mag33(ex_w);
      end
      OP_NORM: begin
        if (maxm[32] | maxm[31]) begin
          ax_q <= ax_q >> 1;
          ay_q <= ay_q >> 1;
        end else begin
          ax_q <= ax_q << 1;
          ay_q <= ay_q << 1;
        end
      end
      OP_SQ_X: sq_q <= 64'(sqx);
      OP_SQ_Y: sq_q <= sq_q + 64'(sqy);
      OP_SQRT_INIT: begin
        sv_q   <= sq_q;
        sr_q   <= '0;
        sbit_q <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sv_q >= st) begin
          sv_q <= sv_q - st;
          sr_q <= (sr_q >> 1) + sbit_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      OP_SET_NX: nx_q <= (!ey_q[32] && ey_q != '0) ? -qn : qn;
      OP_SET_NY: ny_q <= ex_q[32] ? -qn : qn;
      OP_TEST_INIT: have_q <= 1'b0;
      OP_PROJ_INIT: begin
        first_a_q <= 1'b1;
        first_b_q <= 1'b1;
      end
      OP_PROJ_MUL: begin
        mx_q <= rdx * nx_q;
        my_q <= rdy * ny_q;
      end
      OP_PROJ_ACC: begin
        if (cmd_i.sel == POLY_B) begin
          first_b_q <= 1'b0;
          if (first_b_q || dproj < lo_b_q) lo_b_q <= dproj;
          if (first_b_q || dproj > hi_b_q) hi_b_q <= dproj;
        end else begin
          first_a_q <= 1'b0;
          if (first_a_q || dproj < lo_a_q) lo_a_q <= dproj;
          if (first_a_q || dproj > hi_a_q) hi_a_q <= dproj;
        end
      end
      OP_CMP: begin
        if (!gap && (!have_q || ov < best_q)) begin
          have_q <= 1'b1;
          best_q <= ov;
          bnx_q  <= nx_q;
          bny_q  <= ny_q;
        end
      end
      OP_SUM_INIT: begin
        sx_q <= '0;
        sy_q <= '0;
      end
      OP_SUM_ACC: begin
        sx_q <= sx_q + SW'(rdx);
        sy_q <= sy_q + SW'(rdy);
      end
      OP_SET_CX: begin
        if (cmd_i.sel == POLY_B) cbx_q <= sx_q[SW-1] ? -qc : qc;
        else                     cax_q <= sx_q[SW-1] ? -qc : qc;
      end
      OP_SET_CY: begin
        if (cmd_i.sel == POLY_B) cby_q <= sy_q[SW-1] ? -qc : qc;
        else                     cay_q <= sy_q[SW-1] ? -qc : qc;
      end
      OP_DOT_MUL: begin
        m1_q <= bnx_q * dx;
        m2_q <= bny_q * dy;
      end
      OP_DOT_FIX: begin
        // turn the normal to point from A toward B
        if (dsum[52]) begin
          bnx_q <= -bnx_q;
          bny_q <= -bny_q;
        end
      end
      default: ;
    endcase
  end

  assign stat_o.edge_zero = (ex_q == '0) && (ey_q == '0);
  assign stat_o.norm_ok   = (maxm[32:31] == 2'b00) && maxm[30];
  assign stat_o.sqrt_done = (sbit_q == '0);
  assign stat_o.div_busy  = div_busy;
  assign stat_o.gap       = gap;
  assign stat_o.have      = have_q;

  assign nx_o    = bnx_q;
  assign ny_o    = bny_q;
  assign depth_o = (best_q[51:47] != '0) ? 31'h7FFF_FFFF : best_q[46:16];

endmodule

[design/cpsat_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsat_ctrl
// Sequencer: vertex loading, edge walk, projection and centroid loops.
// ----------------------------------------------------------------------------
module cpsat_ctrl
  import cpsat_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int AW           = 4,
  parameter int CW           = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          poly_sel_i,
  input  logic          last_i,
  input  dp_stat_t      stat_i,
  output logic          busy_o,
  output logic          done_o,
  output logic          hit_o,
  output logic          ovf_o,
  output dp_cmd_t       cmd_o,
  output logic [AW-1:0] addr_o,
  output logic [CW-1:0] cnt_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_E_RD, S_E_LATCH, S_E_EDGE, S_E_ZERO, S_NORM, S_SQ_Y,
    S_SQRT_INIT, S_SQRT, S_DIVX_W, S_DIVY, S_DIVY_W, S_P_INIT, S_P_RD,
    S_P_MUL, S_P_ACC, S_CMP, S_HAVE, S_S_INIT, S_S_RD, S_S_ACC, S_CX,
    S_CX_W, S_CY, S_CY_W, S_DOT_MUL, S_DOT_FIX
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic          ovf_q, ovf_d;
  logic          poly_q, poly_d, psel_q, psel_d;
  logic [AW-1:0] i_q, i_d, k_q, k_d;
  logic          done_q, done_d, hit_q, hit_d, ovf_res_q, ovf_res_d;
  logic [CW-1:0] n_edge, n_proj, n_in;
  logic          i_last, k_last;

  assign n_edge = (poly_q == POLY_B) ? cnt_b_q : cnt_a_q;
  assign n_proj = (psel_q == POLY_B) ? cnt_b_q : cnt_a_q;
  assign n_in   = (poly_sel_i == POLY_B) ? cnt_b_q : cnt_a_q;
  assign i_last = (CW'(i_q) + 1'b1) == n_edge;
  assign k_last = (CW'(k_q) + 1'b1) == n_proj;

  always_comb begin
    state_d   = state_q;
    cnt_a_d   = cnt_a_q;
    cnt_b_d   = cnt_b_q;
    ovf_d     = ovf_q;
    poly_d    = poly_q;
    psel_d    = psel_q;
    i_d       = i_q;
    k_d       = k_q;
    done_d    = 1'b0;
    hit_d     = hit_q;
    ovf_res_d = ovf_res_q;
    cmd_o.op  = OP_NONE;
    cmd_o.sel = poly_q;
    addr_o    = i_q;

    case (state_q)
      S_IDLE: begin
        cmd_o.sel = poly_sel_i;
        addr_o    = n_in[AW-1:0];
        if (start_i) begin
          if (n_in < CW'(MAX_VERTICES)) begin
            cmd_o.op = OP_WRITE;
            if (poly_sel_i == POLY_B) cnt_b_d = cnt_b_q + 1'b1;
            else                      cnt_a_d = cnt_a_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cnt_a_q >= CW'(MIN_VERTS) && cnt_b_q >= CW'(MIN_VERTS)) begin
          cmd_o.op = OP_TEST_INIT;
          poly_d   = POLY_A;
          i_d      = '0;
          state_d  = S_E_RD;
        end else begin
          hit_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_E_RD: state_d = S_E_LATCH;
      S_E_LATCH: begin
        cmd_o.op = OP_LATCH_I;
        addr_o   = i_last ? '0 : i_q + 1'b1;
        state_d  = S_E_EDGE;
      end
      S_E_EDGE: begin
        cmd_o.op = OP_EDGE;
        state_d  = S_E_ZERO;
      end
      S_E_ZERO: state_d = stat_i.edge_zero ? S_HAVE : S_NORM;
      S_NORM: begin
        if (stat_i.norm_ok) begin
          cmd_o.op = OP_SQ_X;
          state_d  = S_SQ_Y;
        end else begin
          cmd_o.op = OP_NORM;
        end
      end
      S_SQ_Y: begin
        cmd_o.op = OP_SQ_Y;
        state_d  = S_SQRT_INIT;
      end
      S_SQRT_INIT: begin
        cmd_o.op = OP_SQRT_INIT;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        if (stat_i.sqrt_done) begin
          cmd_o.op = OP_DIV_X;
          state_d  = S_DIVX_W;
        end else begin
          cmd_o.op = OP_SQRT_STEP;
        end
      end
      S_DIVX_W: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_SET_NX;
          state_d  = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd_o.op = OP_DIV_Y;
        state_d  = S_DIVY_W;
      end
      S_DIVY_W: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_SET_NY;
          state_d  = S_P_INIT;
        end
      end
      S_P_INIT: begin
        cmd_o.op = OP_PROJ_INIT;
        psel_d   = POLY_A;
        k_d      = '0;
        state_d  = S_P_RD;
      end
      S_P_RD: begin
        cmd_o.sel = psel_q;
        addr_o    = k_q;
        state_d   = S_P_MUL;
      end
      S_P_MUL: begin
        cmd_o.op = OP_PROJ_MUL;
        state_d  = S_P_ACC;
      end
      S_P_ACC: begin
        cmd_o.op  = OP_PROJ_ACC;
        cmd_o.sel = psel_q;
        if (!k_last) begin
          k_d     = k_q + 1'b1;
          state_d = S_P_RD;
        end else if (psel_q == POLY_A) begin
          psel_d  = POLY_B;
          k_d     = '0;
          state_d = S_P_RD;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.op = OP_CMP;
        if (stat_i.gap) begin
          hit_d   = 1'b0;
          state_d = S_IDLE;
        end else begin
          state_d = S_HAVE;
        end
      end
      S_HAVE: begin
        // advance to the next edge, or finish the walk
        if (!i_last) begin
          i_d     = i_q + 1'b1;
          state_d = S_E_RD;
        end else if (poly_q == POLY_A) begin
          poly_d  = POLY_B;
          i_d     = '0;
          state_d = S_E_RD;
        end else if (stat_i.have) begin
          psel_d  = POLY_A;
          state_d = S_S_INIT;
        end else begin
          hit_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_S_INIT: begin
        cmd_o.op = OP_SUM_INIT;
        k_d      = '0;
        state_d  = S_S_RD;
      end
      S_S_RD: begin
        cmd_o.sel = psel_q;
        addr_o    = k_q;
        state_d   = S_S_ACC;
      end
      S_S_ACC: begin
        cmd_o.op = OP_SUM_ACC;
        if (k_last) begin
          state_d = S_CX;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_S_RD;
        end
      end
      S_CX: begin
        cmd_o.op = OP_DIV_CX;
        state_d  = S_CX_W;
      end
      S_CX_W: begin
        if (!stat_i.div_busy) begin
          cmd_o.op  = OP_SET_CX;
          cmd_o.sel = psel_q;
          state_d   = S_CY;
        end
      end
      S_CY: begin
        cmd_o.op = OP_DIV_CY;
        state_d  = S_CY_W;
      end
      S_CY_W: begin
        if (!stat_i.div_busy) begin
          cmd_o.op  = OP_SET_CY;
          cmd_o.sel = psel_q;
          if (psel_q == POLY_A) begin
            psel_d  = POLY_B;
            state_d = S_S_INIT;
          end else begin
            state_d = S_DOT_MUL;
          end
        end
      end
      S_DOT_MUL: begin
        cmd_o.op = OP_DOT_MUL;
        state_d  = S_DOT_FIX;
      end
      S_DOT_FIX: begin
        cmd_o.op = OP_DOT_FIX;
        hit_d    = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // every return to idle from the test ends the pair
    if (state_q != S_IDLE && state_d == S_IDLE) begin
      done_d    = 1'b1;
      ovf_res_d = ovf_q;
      cnt_a_d   = '0;
      cnt_b_d   = '0;
      ovf_d     = 1'b0;
    end
  end

  assign cnt_o = n_proj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      ovf_q     <= 1'b0;
      poly_q    <= POLY_A;
      psel_q    <= POLY_A;
      i_q       <= '0;
      k_q       <= '0;
      done_q    <= 1'b0;
      hit_q     <= 1'b0;
      ovf_res_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_a_q   <= cnt_a_d;
      cnt_b_q   <= cnt_b_d;
      ovf_q     <= ovf_d;
      poly_q    <= poly_d;
      psel_q    <= psel_d;
      i_q       <= i_d;
      k_q       <= k_d;
      done_q    <= done_d;
      hit_q     <= hit_d;
      ovf_res_q <= ovf_res_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign hit_o  = hit_q;
  assign ovf_o  = ovf_res_q;

endmodule

[design/convex_polygon_sat_collision.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_polygon_sat_collision
// Separating-axis collision test of two convex polygons in Q16.16.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  request   | start, busy        | polygon_select_i vertex_x_i vertex_y_i
//            |                    | last_vertex_i
//  result    | done_o (one cycle) | colliding_o normal_x_o normal_y_o depth_o
//            |                    | overflow_o
//
//  a vertex without last_vertex is accepted while busy stays low.
//  the final vertex runs the test: each non-degenerate edge is normalized by
//  shift steps, square-rooted, divided twice and projected over both polygons;
//  degenerate edges are skipped, and a hit adds the centroid work.
//  the divider is serial (one bit a cycle) and the vertex stores are single-port.
//  the result strobe comes in the first cycle with busy low; it cannot be held off.
//  reset clears counts, overflow flag and the sequencer; vertex stores are not cleared.
// ----------------------------------------------------------------------------
module convex_polygon_sat_collision
  import cpsat_pkg::*;
#(
  parameter int MAX_VERTICES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               polygon_select_i,
  input  logic signed [31:0] vertex_x_i,
  input  logic signed [31:0] vertex_y_i,
  input  logic               last_vertex_i,
  output logic               done_o,
  output logic               colliding_o,
  output logic signed [17:0] normal_x_o,
  output logic signed [17:0] normal_y_o,
  output logic [30:0]        depth_o,
  output logic               overflow_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [AW-1:0]      addr;
  logic [CW-1:0]      cnt;
  logic               hit;
  logic signed [17:0] nx, ny;
  logic [30:0]        depth;

  cpsat_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW),
    .CW           (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .poly_sel_i (polygon_select_i),
    .last_i     (last_vertex_i),
    .stat_i     (stat),
    .busy_o     (busy),
    .done_o     (done_o),
    .hit_o      (hit),
    .ovf_o      (overflow_o),
    .cmd_o      (cmd),
    .addr_o     (addr),
    .cnt_o      (cnt)
  );

  cpsat_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW),
    .CW           (CW)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .addr_i  (addr),
    .cnt_i   (cnt),
    .vx_i    (vertex_x_i),
    .vy_i    (vertex_y_i),
    .stat_o  (stat),
    .nx_o    (nx),
    .ny_o    (ny),
    .depth_o (depth)
  );

  // a miss reports a zero normal and depth
  assign colliding_o = hit;
  assign normal_x_o  = hit ? nx : '0;
  assign normal_y_o  = hit ? ny : '0;
  assign depth_o     = hit ? depth : '0;

endmodule

[design/cpsat_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsat_chk
// Port-level checks of the polygon collision block, bound to the top level.
// ----------------------------------------------------------------------------
`include "convex_polygon_sat_collision_assert.svh"

module cpsat_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        last_vertex_i,
  input logic        done_o,
  input logic        colliding_o,
  input logic [17:0] normal_x_o,
  input logic [17:0] normal_y_o,
  input logic [30:0] depth_o
);

  `CPSAT_ASSERT_NOW(a_done_idle, done_o, !busy, "result shown while busy")
  `CPSAT_ASSERT_NEXT(a_done_once, done_o, !done_o, "result strobe longer than one cycle")
  `CPSAT_ASSERT_NOW(a_miss_zero, done_o && !colliding_o,
    normal_x_o == 18'd0 && normal_y_o == 18'd0 && depth_o == 31'd0,
    "miss with nonzero normal or depth")
  `CPSAT_ASSERT_NEXT(a_load_fast, start && !busy && !last_vertex_i, !busy && !done_o,
    "plain vertex load did not complete in one cycle")

endmodule

bind convex_polygon_sat_collision cpsat_chk u_cpsat_chk (.*);
